// ----- hdl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared widths, constants and register indexes of the peak current theft
// detector.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int IN_W        = 10;   // raw sample field width
    localparam int CUR_W       = 11;   // signed current width
    localparam int LOSS_W      = 15;   // signed loss percent width
    localparam int CNT_W       = 10;   // window counter width
    localparam int CFG_W       = 10;   // widest register
    localparam int CFG_IDX_W   = 2;
    localparam int RATIO_W     = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int IN_TDATA_W  = 24;   // 2 x 10 bits, padded to bytes
    localparam int OUT_TDATA_W = 40;   // 11+11+1+15+1 bits, padded to bytes

    // divider: |(sc-lc)*100| fits 18 bits, |sc| fits 10 bits
    localparam int NUM_W       = 18;
    localparam int DEN_W       = 10;
    localparam int STEP_W      = $clog2(NUM_W);

    localparam int CUR_MAX     = 1023;
    localparam int LOSS_MAX    = 9999;
    localparam int PCT_SCALE   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THEFT_RATIO   = 2'd2;

    localparam logic [CNT_W-1:0]   WINDOW_LENGTH_RST = 10'd200;
    localparam logic [IN_W-1:0]    ZERO_OFFSET_RST   = 10'd486;
    localparam logic [RATIO_W-1:0] THEFT_RATIO_RST   = 8'd103;

endpackage

// ----- hdl/peak_current_theft_detector_top.sv -----
// ----------------------------------------------------------------------------
// peak_current_theft_detector_top
// Windowed peak detector for a supply and a load current sensor with theft
// flag and loss percentage per window.
// ----------------------------------------------------------------------------
// Usage:
//   Sample pairs enter on s_axis, one item per cycle while s_axis_tready is
//   high. Each item updates the supply and load peaks held in two lanes.
//   The item that closes a window (window_length pairs; a length of 0 acts
//   as 1) starts the merge stage, and one result item leaves on m_axis:
//   the currents are captured with the closing item, then the PREP state
//   forms the products, the DIV state runs the bit-serial divider for the
//   loss percent and the HOLD state loads the output register.
//   s_axis_tready is low from the window-closing item until the result has
//   been loaded into the output register. Pairs of the next window are
//   taken while the result waits on a stalled m_axis; if that window also
//   closes first, the block holds its finished result and input until the
//   output frees.
//   Reset clears the peaks, the window counter and the output valid, and
//   sets the registers to window 200, offset 486, ratio 103 percent.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wr_data;
//   the user must write them only while the block is idle, as the block
//   does not enforce it; index 3 is ignored.
// ----------------------------------------------------------------------------
module peak_current_theft_detector_top #(
    parameter int SAMPLE_BITS = pctd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pctd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pctd_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] supply_sample, [19:10] load_sample, [23:20] zero
    input  logic [pctd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [10:0] supply_current, [21:11] load_current, [22] theft_detected,
    // [37:23] loss_percent, [38] divide_by_zero, [39] zero
    output logic [pctd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [pctd_pkg::CNT_W-1:0]         window_length_reg;
    logic [pctd_pkg::IN_W-1:0]          zero_offset_reg;
    logic [pctd_pkg::RATIO_W-1:0]       theft_ratio_reg;
    logic [pctd_pkg::CNT_W-1:0]         count_reg;
    logic [pctd_pkg::CNT_W-1:0]         count_next;

    logic                               accept;
    logic                               win_end;
    logic                               merge_idle;
    logic signed [pctd_pkg::CUR_W-1:0]  supply_current;
    logic signed [pctd_pkg::CUR_W-1:0]  load_current;

    assign s_axis_tready = merge_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign count_next    = count_reg + 1'b1;
    // end the window on counter wrap or once the length is reached
    assign win_end       = accept && ((count_next == '0) ||
                                      (count_next >= window_length_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= pctd_pkg::WINDOW_LENGTH_RST;
            zero_offset_reg   <= pctd_pkg::ZERO_OFFSET_RST;
            theft_ratio_reg   <= pctd_pkg::THEFT_RATIO_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pctd_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wr_data;
                pctd_pkg::REG_ZERO_OFFSET:   zero_offset_reg   <= cfg_wr_data;
                pctd_pkg::REG_THEFT_RATIO:
                    theft_ratio_reg <= cfg_wr_data[pctd_pkg::RATIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= win_end ? '0 : count_next;
    end

    pctd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_supply_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .win_end     (win_end),
        .sample      (s_axis_tdata[pctd_pkg::IN_W-1:0]),
        .zero_offset (zero_offset_reg),
        .current     (supply_current)
    );

    pctd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_load_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .win_end     (win_end),
        .sample      (s_axis_tdata[2*pctd_pkg::IN_W-1:pctd_pkg::IN_W]),
        .zero_offset (zero_offset_reg),
        .current     (load_current)
    );

    pctd_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (win_end),
        .supply_current (supply_current),
        .load_current   (load_current),
        .theft_ratio    (theft_ratio_reg),
        .idle           (merge_idle),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

// ----- hdl/pctd_lane.sv -----
// ----------------------------------------------------------------------------
// pctd_lane
// One sensor channel: peak hold over the window and offset removal with
// clamping to the signed current range.
// ----------------------------------------------------------------------------
module pctd_lane #(
    parameter int SAMPLE_BITS = pctd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              win_end,
    input  logic [pctd_pkg::IN_W-1:0]         sample,
    input  logic [pctd_pkg::IN_W-1:0]         zero_offset,
    output logic signed [pctd_pkg::CUR_W-1:0] current
);

    localparam int DW = (SAMPLE_BITS + 2 > 12) ? SAMPLE_BITS + 2 : 12;

    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [SAMPLE_BITS-1:0] samp;
    logic signed [DW-1:0]   diff;

    assign samp      = SAMPLE_BITS'(sample);
    assign peak_next = (samp > peak_reg) ? samp : peak_reg;

    assign diff = $signed(DW'(peak_next)) - $signed(DW'(zero_offset));

    always_comb
    begin
        if (diff > $signed(DW'(pctd_pkg::CUR_MAX)))
            current = pctd_pkg::CUR_W'(pctd_pkg::CUR_MAX);
        else if (diff < -$signed(DW'(pctd_pkg::CUR_MAX)))
            current = -pctd_pkg::CUR_W'(pctd_pkg::CUR_MAX);
        else
            current = diff[pctd_pkg::CUR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_reg <= '0;
        else if (accept)
            peak_reg <= win_end ? '0 : peak_next;
    end

endmodule

// ----- hdl/pctd_merge.sv -----
// ----------------------------------------------------------------------------
// pctd_merge
// Merge stage: theft compare, loss percent through a bit-serial divider,
// and the output register.
// ----------------------------------------------------------------------------
module pctd_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [pctd_pkg::CUR_W-1:0]     supply_current,
    input  logic signed [pctd_pkg::CUR_W-1:0]     load_current,
    input  logic [pctd_pkg::RATIO_W-1:0]          theft_ratio,
    output logic                                  idle,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pctd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int TW = 20;   // theft product width
    localparam int PW = pctd_pkg::NUM_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                              state_reg;
    logic signed [pctd_pkg::CUR_W-1:0]   sc_reg;
    logic signed [pctd_pkg::CUR_W-1:0]   lc_reg;
    logic                                theft_reg;
    logic                                dz_reg;
    logic                                neg_reg;
    logic [pctd_pkg::DEN_W-1:0]          den_reg;
    logic [pctd_pkg::DEN_W-1:0]          rem_reg;
    logic [pctd_pkg::NUM_W-1:0]          qsh_reg;
    logic [pctd_pkg::STEP_W-1:0]         step_reg;
    logic                                out_valid_reg;
    logic [pctd_pkg::OUT_TDATA_W-1:0]    out_data_reg;

    logic signed [TW-1:0]                 theft_s;
    logic signed [TW-1:0]                 theft_l;
    logic signed [pctd_pkg::CUR_W:0]      diff;
    logic signed [PW-1:0]                 prod;
    logic [PW-1:0]                        prod_abs;
    logic [pctd_pkg::CUR_W-1:0]           sc_abs;
    logic [pctd_pkg::DEN_W:0]             trial;
    logic                                 qbit;
    logic [pctd_pkg::DEN_W-1:0]           rem_step;
    logic [pctd_pkg::NUM_W-1:0]           q_sat;
    logic signed [pctd_pkg::LOSS_W-1:0]   loss;
    logic [pctd_pkg::OUT_TDATA_W-1:0]     result;
    logic                                 load_out;

    // theft and numerator products from the captured currents
    assign theft_s  = TW'(sc_reg) * $signed(TW'(pctd_pkg::PCT_SCALE));
    assign theft_l  = TW'(lc_reg) * $signed(TW'({1'b0, theft_ratio}));
    assign diff     = (pctd_pkg::CUR_W + 1)'(sc_reg) - (pctd_pkg::CUR_W + 1)'(lc_reg);
    assign prod     = PW'(diff) * $signed(PW'(pctd_pkg::PCT_SCALE));
    assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);
    assign sc_abs   = sc_reg[pctd_pkg::CUR_W-1] ? pctd_pkg::CUR_W'(-sc_reg)
                                                : pctd_pkg::CUR_W'(sc_reg);

    // one restoring division step
    assign trial    = {rem_reg, qsh_reg[pctd_pkg::NUM_W-1]};
    assign qbit     = (trial >= {1'b0, den_reg});
    assign rem_step = qbit ? pctd_pkg::DEN_W'(trial - {1'b0, den_reg})
                           : trial[pctd_pkg::DEN_W-1:0];

    // saturate the magnitude, then apply the sign
    always_comb
    begin
        if (qsh_reg > pctd_pkg::NUM_W'(pctd_pkg::LOSS_MAX))
            q_sat = pctd_pkg::NUM_W'(pctd_pkg::LOSS_MAX);
        else
            q_sat = qsh_reg;
        if (dz_reg)
            loss = '0;
        else if (neg_reg)
            loss = -$signed(pctd_pkg::LOSS_W'(q_sat));
        else
            loss = $signed(pctd_pkg::LOSS_W'(q_sat));
    end

    assign result = {1'b0, dz_reg, loss, theft_reg, lc_reg, sc_reg};

    // load once the output register is free
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                        state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sc_reg <= supply_current;
                    lc_reg <= load_current;
                end
            end
            ST_PREP:
            begin
                theft_reg <= (theft_s > theft_l);
                dz_reg    <= (sc_reg == '0);
                neg_reg   <= prod[PW-1] ^ sc_reg[pctd_pkg::CUR_W-1];
                den_reg   <= sc_abs[pctd_pkg::DEN_W-1:0];
                rem_reg   <= '0;
                qsh_reg   <= prod_abs[pctd_pkg::NUM_W-1:0];
                step_reg  <= pctd_pkg::STEP_W'(pctd_pkg::NUM_W - 1);
            end
            ST_DIV:
            begin
                rem_reg  <= rem_step;
                qsh_reg  <= {qsh_reg[pctd_pkg::NUM_W-2:0], qbit};
                step_reg <= step_reg - 1'b1;
            end
            ST_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign idle          = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- tb/sv/peak_current_theft_detector_top_test.sv -----
// ----------------------------------------------------------------------------
// peak_current_theft_detector_top_test
// Self-checking bench for the windowed peak current theft detector. Sample
// pairs stream in under random gaps and output stalls. A scoreboard tracks
// the window peaks and registers and predicts each window result. Every
// returned item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module peak_current_theft_detector_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pctd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE       = 30;     // result latency plus margin
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1340;
    localparam int MIN_WINDOWS  = 60;

    typedef struct packed {
        logic                               divide_by_zero;
        logic signed [pctd_pkg::LOSS_W-1:0] loss_percent;
        logic                               theft_detected;
        logic signed [pctd_pkg::CUR_W-1:0]  load_current;
        logic signed [pctd_pkg::CUR_W-1:0]  supply_current;
    } window_result_t;

    class theft_window_scoreboard;
        logic [pctd_pkg::CNT_W-1:0]   window_len;
        logic [pctd_pkg::IN_W-1:0]    offset;
        logic [pctd_pkg::RATIO_W-1:0] ratio;
        logic [pctd_pkg::CNT_W-1:0]   pair_count;
        logic [pctd_pkg::IN_W-1:0]    supply_peak;
        logic [pctd_pkg::IN_W-1:0]    load_peak;
        window_result_t     pending_windows[$];
        int errors;
        int pairs_seen;
        int windows_seen;
        int zero_supply_seen;
        int theft_seen;

        function new();
            window_len   = pctd_pkg::WINDOW_LENGTH_RST;
            offset       = pctd_pkg::ZERO_OFFSET_RST;
            ratio        = pctd_pkg::THEFT_RATIO_RST;
            pair_count   = '0;
            supply_peak  = '0;
            load_peak    = '0;
            errors       = 0;
            pairs_seen   = 0;
            windows_seen = 0;
            zero_supply_seen = 0;
            theft_seen   = 0;
        endfunction

        function int clamp(int v, int lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void write_reg(logic [pctd_pkg::CFG_IDX_W-1:0] idx,
                                logic [pctd_pkg::CFG_W-1:0] val);
            case (idx)
                pctd_pkg::REG_WINDOW_LENGTH: window_len = val;
                pctd_pkg::REG_ZERO_OFFSET:   offset     = val;
                pctd_pkg::REG_THEFT_RATIO:   ratio      = val[pctd_pkg::RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pair(logic [pctd_pkg::IN_W-1:0] supply,
                                logic [pctd_pkg::IN_W-1:0] load);
            int sc;
            int lc;
            int pct;
            int loss;
            window_result_t res;
            pairs_seen++;
            if (supply > supply_peak)
                supply_peak = supply;
            if (load > load_peak)
                load_peak = load;
            pair_count = pair_count + 1'b1;
            if (pair_count != 0 && pair_count < window_len)
                return;
            sc = int'(supply_peak);
            sc = clamp(sc - int'(offset), pctd_pkg::CUR_MAX);
            lc = int'(load_peak);
            lc = clamp(lc - int'(offset), pctd_pkg::CUR_MAX);
            // keep the ratio in a signed int so the compare stays signed
            pct = int'(ratio);
            res.supply_current = sc[pctd_pkg::CUR_W-1:0];
            res.load_current   = lc[pctd_pkg::CUR_W-1:0];
            res.theft_detected = (sc * pctd_pkg::PCT_SCALE) > (lc * pct);
            res.divide_by_zero = (sc == 0);
            loss = (sc == 0) ? 0 : clamp(((sc - lc) * pctd_pkg::PCT_SCALE) / sc,
                                         pctd_pkg::LOSS_MAX);
            res.loss_percent   = loss[pctd_pkg::LOSS_W-1:0];
            pending_windows.push_back(res);
            pair_count  = '0;
            supply_peak = '0;
            load_peak   = '0;
        endfunction

        function void check_window(logic [pctd_pkg::OUT_TDATA_W-1:0] data);
            window_result_t got;
            window_result_t want;
            got = data[$bits(window_result_t)-1:0];
            if (pending_windows.size() == 0)
            begin
                errors++;
                $error("window result arrived with none outstanding: %h", data);
                return;
            end
            want = pending_windows.pop_front();
            windows_seen++;
            if (want.divide_by_zero)
                zero_supply_seen++;
            if (want.theft_detected)
                theft_seen++;
            if (got.supply_current !== want.supply_current)
            begin
                errors++;
                $error("supply_current: expected %0d, got %0d",
                       want.supply_current, got.supply_current);
            end
            if (got.load_current !== want.load_current)
            begin
                errors++;
                $error("load_current: expected %0d, got %0d",
                       want.load_current, got.load_current);
            end
            if (got.theft_detected !== want.theft_detected)
            begin
                errors++;
                $error("theft_detected: expected %0d, got %0d",
                       want.theft_detected, got.theft_detected);
            end
            if (got.loss_percent !== want.loss_percent)
            begin
                errors++;
                $error("loss_percent: expected %0d, got %0d",
                       want.loss_percent, got.loss_percent);
            end
            if (got.divide_by_zero !== want.divide_by_zero)
            begin
                errors++;
                $error("divide_by_zero: expected %0d, got %0d",
                       want.divide_by_zero, got.divide_by_zero);
            end
        endfunction

        function int pending();
            return pending_windows.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [pctd_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [pctd_pkg::CFG_W-1:0]         cfg_wr_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // [9:0] supply_sample, [19:10] load_sample, [23:20] zero
    logic [pctd_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [10:0] supply_current, [21:11] load_current, [22] theft_detected,
    // [37:23] loss_percent, [38] divide_by_zero, [39] zero
    logic [pctd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

    theft_window_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    bit long_hold_req;
    int supply_hi;
    int load_hi;
    int settings_done;

    peak_current_theft_detector_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_pair(input logic [pctd_pkg::IN_W-1:0] supply,
                             input logic [pctd_pkg::IN_W-1:0] load);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, load, supply};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pair(supply, load);
    endtask

    // hold input until every window result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [pctd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pctd_pkg::CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [pctd_pkg::CFG_W-1:0] wl,
                                input logic [pctd_pkg::CFG_W-1:0] off,
                                input logic [pctd_pkg::CFG_W-1:0] ratio);
        drain();
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, wl);
        cfg_write(pctd_pkg::REG_ZERO_OFFSET, off);
        cfg_write(pctd_pkg::REG_THEFT_RATIO, ratio);
        settings_done++;
    endtask

    // pick the upper bound of each channel so window peaks land on the offset,
    // around it, anywhere in range or at the rails
    task automatic pick_levels();
        int off;
        off = int'(sb.offset);
        case ($urandom_range(0, 5))
            0:
            begin
                supply_hi = off;
                load_hi   = $urandom_range(0, 1023);
            end
            1:
            begin
                supply_hi = $urandom_range(0, 1023);
                load_hi   = $urandom_range(0, 1023);
            end
            2:
            begin
                supply_hi = off + $urandom_range(0, 16) - 8;
                load_hi   = off + $urandom_range(0, 16) - 8;
            end
            3:
            begin
                supply_hi = $urandom_range(0, 1) ? 1023 : 0;
                load_hi   = $urandom_range(0, 1) ? 1023 : 0;
            end
            default:
            begin
                supply_hi = off + $urandom_range(0, 200) - 60;
                load_hi   = supply_hi - $urandom_range(0, 80) + 10;
            end
        endcase
        if (supply_hi < 0) supply_hi = 0;
        if (supply_hi > 1023) supply_hi = 1023;
        if (load_hi < 0) load_hi = 0;
        if (load_hi > 1023) load_hi = 1023;
    endtask

    task automatic send_random(input int count);
        logic [pctd_pkg::IN_W-1:0] supply;
        logic [pctd_pkg::IN_W-1:0] load;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                pick_levels();
            if ($urandom_range(0, 9) == 0)
            begin
                supply = pctd_pkg::IN_W'($urandom_range(0, 1023));
                load   = pctd_pkg::IN_W'($urandom_range(0, 1023));
            end
            else
            begin
                supply = ($urandom_range(0, 7) == 0) ? pctd_pkg::IN_W'(supply_hi)
                         : pctd_pkg::IN_W'($urandom_range(0, supply_hi));
                load   = ($urandom_range(0, 7) == 0) ? pctd_pkg::IN_W'(load_hi)
                         : pctd_pkg::IN_W'($urandom_range(0, load_hi));
            end
            send_pair(supply, load);
        end
    endtask

    task automatic random_phase(input bit huge);
        logic [pctd_pkg::CFG_W-1:0] wl;
        logic [pctd_pkg::CFG_W-1:0] off;
        logic [pctd_pkg::CFG_W-1:0] ratio;
        int span;
        case ($urandom_range(0, 9))
            0: wl = 0;
            1: wl = 1;
            2: wl = 20;
            8: wl = pctd_pkg::CFG_W'($urandom_range(31, 80));
            9: wl = pctd_pkg::CFG_W'($urandom_range(81, 150));
            default: wl = pctd_pkg::CFG_W'($urandom_range(2, 30));
        endcase
        if (huge)
            wl = 1023;
        case ($urandom_range(0, 5))
            0: off = 0;
            1: off = 1023;
            2: off = pctd_pkg::ZERO_OFFSET_RST;
            default: off = pctd_pkg::CFG_W'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 6))
            0: ratio = 100;
            1: ratio = 200;
            2: ratio = pctd_pkg::CFG_W'($urandom_range(0, 255));
            3: ratio = {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
            default: ratio = pctd_pkg::CFG_W'($urandom_range(100, 200));
        endcase
        program_regs(wl, off, ratio);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        pick_levels();
        span = (wl == 0) ? 1 : int'(wl);
        if (huge || wl > 80)
            send_random(span + $urandom_range(0, 2));
        else
            send_random(span * $urandom_range(1, 3) + $urandom_range(0, 2));
    endtask

    // receiver: check accepted results and drive output backpressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_axis_tvalid && m_axis_tready)
                    sb.check_window(m_axis_tdata);
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    stall_left = LONG_HOLD - 1;
                    m_axis_tready <= 1'b0;
                end
                else if (rx_idle && $urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 18) - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no item moved for %0d cycles, %0d window results outstanding",
               QUIET_LIMIT, sb.pending());
        $display("peak_current_theft_detector_top_test failed");
        $finish;
    end

    initial
    begin
        bit huge_done;
        huge_done     = 1'b0;
        settings_done = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        supply_hi     = 1023;
        load_hi       = 1023;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= pctd_pkg::REG_WINDOW_LENGTH;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one result per pair, default offset and ratio
        cfg_write(REG_UNUSED, '1);
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, 0);
        settings_done++;
        send_pair(0, 0);
        send_pair(1023, 1023);
        send_pair(0, 1023);
        send_pair(1023, 0);
        send_pair(486, 486);          // zero supply, no theft
        send_pair(486, 0);            // zero supply, theft still flagged
        send_pair(487, 0);            // loss saturates high
        send_pair(487, 1023);         // loss saturates low
        send_pair(485, 1023);         // negative supply, loss saturates high
        send_pair(600, 590);
        send_pair(590, 600);
        send_pair(10'h155, 10'h2AA);
        send_pair(10'h2AA, 10'h155);
        drain();
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, 1);
        send_pair(700, 650);
        // peak starts at zero and only moves on a strictly larger sample
        drain();
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, 3);
        send_pair(500, 500);
        send_pair(499, 501);
        send_pair(500, 400);
        // shorten the window mid-way: the next pair closes it
        drain();
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, 40);
        for (int i = 0; i < 5; i++)
            send_pair(pctd_pkg::IN_W'(550 + i * 7), pctd_pkg::IN_W'(540 + i * 3));
        drain();
        cfg_write(pctd_pkg::REG_WINDOW_LENGTH, 3);
        settings_done++;
        send_pair(520, 530);

        // fill the block against a long output hold
        program_regs(0, pctd_pkg::ZERO_OFFSET_RST, 150);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        long_hold_req = 1'b1;
        pick_levels();
        send_random(40);

        while (sb.pairs_seen < ITEM_TARGET || sb.windows_seen < MIN_WINDOWS)
        begin
            if (!huge_done && sb.pairs_seen >= 250)
            begin
                random_phase(1'b1);
                huge_done = 1'b1;
            end
            else
                random_phase(1'b0);
        end

        // closing stretch with no gaps and no stalls
        program_regs(5, pctd_pkg::ZERO_OFFSET_RST,
                     pctd_pkg::CFG_W'(pctd_pkg::THEFT_RATIO_RST));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        pick_levels();
        send_random(70);
        drain();

        $display("Checked %0d window results from %0d sample pairs over %0d register settings",
                 sb.windows_seen, sb.pairs_seen, settings_done);
        $display("Windows with zero supply: %0d, with theft flagged: %0d",
                 sb.zero_supply_seen, sb.theft_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("peak_current_theft_detector_top_test passed");
        else
            $display("peak_current_theft_detector_top_test failed");
        $finish;
    end

endmodule
